/* rtl/core/sipf_pkg.sv */
// ----------------------------------------------------------------------------
// sipf_pkg: shared types and constants
// Widths, character codes and the record passed from front to back end of
// the SI prefix value formatter.
// ----------------------------------------------------------------------------
package sipf_pkg;

   localparam int VAL_W          = 32;   // raw value width
   localparam int EXP_W          = 6;    // input exponent width
   localparam int EXPO_W         = 8;    // working exponent width
   localparam int CHR_W          = 8;    // character width
   localparam int NDIG           = 10;   // BCD digits for a 32-bit value
   localparam int LEN_W          = 4;    // digit count width
   localparam int CNT_W          = 5;    // characters per item width
   localparam int DD_BITS        = 2;    // binary bits converted per cycle
   localparam int NUM_PREFIX     = 7;
   localparam int CSR_IDX_W      = 3;
   localparam int MAX_DIGITS_DEF = 4;
   localparam int QDEPTH_DEF     = 2;

   localparam logic [CHR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHR_W-1:0] CHAR_DOT   = 8'd46;
   localparam logic [CHR_W-1:0] CHAR_MINUS = 8'd45;

   // lowest exponent that still has a prefix entry (pico)
   localparam logic signed [EXPO_W-1:0] EXPO_PICO = -8'sd12;

   typedef logic [NDIG-1:0][3:0]               bcd_type;
   typedef logic [NUM_PREFIX-1:0][CHR_W-1:0]   prefix_tab_type;

   // reset values: pico, nano, micro, milli, unity, kilo, mega
   localparam prefix_tab_type PREFIX_RESET = {8'd77, 8'd107, 8'd0, 8'd109,
                                              8'd117, 8'd110, 8'd112};

   typedef struct packed {
      logic                     neg;
      bcd_type                  digits;
      logic [LEN_W-1:0]         len;
      logic signed [EXPO_W-1:0] expo;
      logic [CHR_W-1:0]         unit;
   } rec_type;

endpackage

/* rtl/core/sipf_front.sv */
// ----------------------------------------------------------------------------
// sipf_front: item intake, magnitude, BCD conversion and rounding
// Takes one item, converts the magnitude to BCD a few bits per cycle, then
// drops and rounds low digits until the count fits, and queues the record.
// ----------------------------------------------------------------------------
module sipf_front #(
   parameter int MAX_DIGITS = sipf_pkg::MAX_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [sipf_pkg::VAL_W-1:0]          req_value,
   input  logic signed [sipf_pkg::EXP_W-1:0]   req_exponent,
   input  logic [sipf_pkg::CHR_W-1:0]          req_unit,
   input  logic                                q_full,
   output logic                                q_push,
   output sipf_pkg::rec_type                   q_data
);
   import sipf_pkg::*;

   localparam int CONV_STEPS = VAL_W / DD_BITS;
   localparam int CONV_W     = $clog2(CONV_STEPS);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_ROUND, ST_PUSH} state_type;

   state_type                state_ff;
   logic                     neg_ff;
   logic [VAL_W-1:0]         bin_ff;
   bcd_type                  bcd_ff;
   logic [CONV_W-1:0]        cnt_ff;
   logic signed [EXPO_W-1:0] expo_ff;
   logic [CHR_W-1:0]         unit_ff;

   logic                     req_neg;
   logic [VAL_W-1:0]         req_mag;
   bcd_type                  conv_bcd;
   logic [VAL_W-1:0]         conv_bin;
   bcd_type                  shifted;
   bcd_type                  rnd_bcd;
   logic                     carry;
   logic [LEN_W-1:0]         cur_len;

   // one double-dabble step: add 3 to digits of 5 or more, shift a bit in
   function automatic bcd_type dd_step(bcd_type b, logic bit_in);
      bcd_type         t;
      logic [4*NDIG:0] w;
      for (int i = 0; i < NDIG; i++)
         t[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
      w = {t, bit_in};
      return w[4*NDIG-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] bcd_len(bcd_type b);
      logic [LEN_W-1:0] n;
      n = LEN_W'(1);
      for (int i = 1; i < NDIG; i++)
         if (b[i] != 4'd0) n = LEN_W'(i + 1);
      return n;
   endfunction

   assign req_neg = req_func & req_value[VAL_W-1];
   // two's complement of the most negative value is 2^31 itself
   assign req_mag = req_neg ? (~req_value + VAL_W'(1)) : req_value;

   always_comb begin
      conv_bcd = bcd_ff;
      conv_bin = bin_ff;
      for (int i = 0; i < DD_BITS; i++) begin
         conv_bcd = dd_step(conv_bcd, conv_bin[VAL_W-1]);
         conv_bin = conv_bin << 1;
      end
   end

   // (mag + 5) / 10: drop the low digit, increment if it was 5 or more
   always_comb begin
      shifted = bcd_type'({4'd0, bcd_ff[NDIG-1:1]});
      carry   = (bcd_ff[0] >= 4'd5);
      for (int i = 0; i < NDIG; i++) begin
         rnd_bcd[i] = carry ? ((shifted[i] == 4'd9) ? 4'd0 : shifted[i] + 4'd1)
                            : shifted[i];
         carry      = carry & (shifted[i] == 4'd9);
      end
   end

   assign cur_len = bcd_len(bcd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  neg_ff   <= req_neg;
                  bin_ff   <= req_mag;
                  bcd_ff   <= '0;
                  cnt_ff   <= '0;
                  expo_ff  <= EXPO_W'(req_exponent);
                  unit_ff  <= req_unit;
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff <= conv_bcd;
               bin_ff <= conv_bin;
               cnt_ff <= cnt_ff + CONV_W'(1);
               if (cnt_ff == CONV_W'(CONV_STEPS - 1)) state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (cur_len > LEN_W'(MAX_DIGITS)) begin
                  bcd_ff  <= rnd_bcd;
                  expo_ff <= expo_ff + EXPO_W'(1);
               end else begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!q_full) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign q_push = (state_ff == ST_PUSH) && !q_full;

   always_comb begin
      q_data.neg    = neg_ff;
      q_data.digits = bcd_ff;
      q_data.len    = cur_len;
      q_data.expo   = expo_ff;
      q_data.unit   = unit_ff;
   end

endmodule

/* rtl/core/sipf_queue.sv */
// ----------------------------------------------------------------------------
// sipf_queue: small record FIFO between front and back end
// Register based, one push and one pop port, full and empty flags.
// ----------------------------------------------------------------------------
module sipf_queue #(
   parameter int DEPTH = sipf_pkg::QDEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sipf_pkg::rec_type data_in,
   output logic              full,
   input  logic              pop,
   output sipf_pkg::rec_type data_out,
   output logic              empty
);
   import sipf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);

   rec_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic               do_push;
   logic               do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = (occ_ff == OCC_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop)      occ_ff <= occ_ff + OCC_W'(1);
         else if (do_pop && !do_push) occ_ff <= occ_ff - OCC_W'(1);
      end
   end

endmodule

/* rtl/core/sipf_back.sv */
// ----------------------------------------------------------------------------
// sipf_back: character sequencer
// Pops a record, works out prefix and decimal point placement, then sends
// one character per cycle: sign, leading zero, digits, point, prefix, unit.
// ----------------------------------------------------------------------------
module sipf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  sipf_pkg::rec_type             q_data,
   output logic                          q_pop,
   input  sipf_pkg::prefix_tab_type      prefix_tab,
   output logic                          rsp_valid,
   output logic [sipf_pkg::CHR_W-1:0]    rsp_char_out,
   output logic                          rsp_last
);
   import sipf_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_SETUP, B_SIGN, B_LEAD0, B_LEADDOT, B_LEAD00,
      B_DIG, B_DOT, B_PREFIX, B_UNIT
   } state_type;

   state_type          state_ff;
   rec_type            rec_ff;
   logic [CHR_W-1:0]   pfx_ff;
   logic               lead_ff;
   logic               lead00_ff;
   logic               dot_en_ff;
   logic [LEN_W-1:0]   dotpos_ff;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   sent_ff;
   logic [LEN_W-1:0]   k_ff;
   logic               rsp_valid_ff;
   logic [CHR_W-1:0]   rsp_char_ff;
   logic               rsp_last_ff;

   // setup terms
   logic signed [EXPO_W-1:0] e_s;
   logic                     in_tab;
   logic [5:0]               e_p2;
   logic [11:0]              prod;
   logic [4:0]               step_idx;
   logic [6:0]               off7;
   logic [1:0]               off;
   logic [CHR_W-1:0]         pfx;
   logic                     lead;
   logic                     lead00;
   logic                     dot_en;
   logic [CNT_W-1:0]         total;

   // emit terms
   logic                     is_emit;
   logic [CHR_W-1:0]         emit_char;
   state_type                emit_next;
   state_type                tail_next;
   logic [LEN_W-1:0]         dig_idx;
   logic [LEN_W-1:0]         len_m1;

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      e_s      = rec_ff.expo - EXPO_PICO;
      in_tab   = (rec_ff.expo >= EXPO_PICO);
      e_p2     = e_s[5:0] + 6'd2;
      // ceil(e / 3) = (e + 2) * 43 >> 7, exact for e below 62
      prod     = {6'd0, e_p2} * 12'd43;
      step_idx = prod[11:7];
      off7     = {2'd0, step_idx} + {1'b0, step_idx, 1'b0} - {1'b0, e_s[5:0]};
      off      = in_tab ? off7[1:0] : 2'd0;
      pfx      = (in_tab && (step_idx < 5'(NUM_PREFIX))) ? prefix_tab[step_idx[2:0]]
                                                         : '0;
      lead     = (rec_ff.len <= {2'd0, off});
      lead00   = (rec_ff.len <  {2'd0, off});
      dot_en   = (off != 2'd0) && (rec_ff.len > {2'd0, off});
      total    = CNT_W'(rec_ff.neg) + (lead ? CNT_W'(2) : '0) + CNT_W'(lead00)
               + CNT_W'(rec_ff.len) + CNT_W'(dot_en) + CNT_W'(pfx != '0)
               + CNT_W'(rec_ff.unit != '0);
   end

   assign len_m1  = rec_ff.len - LEN_W'(1);
   assign dig_idx = len_m1 - k_ff;

   always_comb begin
      tail_next = (pfx_ff != '0) ? B_PREFIX :
                  (rec_ff.unit != '0) ? B_UNIT : B_IDLE;
      is_emit   = 1'b1;
      emit_char = CHAR_ZERO;
      emit_next = B_IDLE;
      case (state_ff)
         B_SIGN: begin
            emit_char = CHAR_MINUS;
            emit_next = lead_ff ? B_LEAD0 : B_DIG;
         end
         B_LEAD0: begin
            emit_char = CHAR_ZERO;
            emit_next = B_LEADDOT;
         end
         B_LEADDOT: begin
            emit_char = CHAR_DOT;
            emit_next = lead00_ff ? B_LEAD00 : B_DIG;
         end
         B_LEAD00: begin
            emit_char = CHAR_ZERO;
            emit_next = B_DIG;
         end
         B_DIG: begin
            emit_char = CHAR_ZERO + {4'd0, rec_ff.digits[dig_idx]};
            if (dot_en_ff && (k_ff == dotpos_ff)) emit_next = B_DOT;
            else if (k_ff == len_m1)              emit_next = tail_next;
            else                                  emit_next = B_DIG;
         end
         B_DOT: begin
            emit_char = CHAR_DOT;
            emit_next = (k_ff == rec_ff.len) ? tail_next : B_DIG;
         end
         B_PREFIX: begin
            emit_char = pfx_ff;
            emit_next = (rec_ff.unit != '0) ? B_UNIT : B_IDLE;
         end
         B_UNIT: begin
            emit_char = rec_ff.unit;
            emit_next = B_IDLE;
         end
         default: is_emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  rec_ff   <= q_data;
                  state_ff <= B_SETUP;
               end
            end
            B_SETUP: begin
               pfx_ff    <= pfx;
               lead_ff   <= lead;
               lead00_ff <= lead00;
               dot_en_ff <= dot_en;
               dotpos_ff <= rec_ff.len - LEN_W'(off) - LEN_W'(1);
               total_ff  <= total;
               sent_ff   <= '0;
               k_ff      <= '0;
               state_ff  <= rec_ff.neg ? B_SIGN : (lead ? B_LEAD0 : B_DIG);
            end
            default: begin
               if (is_emit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_char_ff  <= emit_char;
                  rsp_last_ff  <= (sent_ff == total_ff - CNT_W'(1));
                  sent_ff      <= sent_ff + CNT_W'(1);
                  if (state_ff == B_DIG) k_ff <= k_ff + LEN_W'(1);
                  state_ff     <= emit_next;
               end else begin
                  state_ff <= B_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* rtl/core/si_prefix_value_formatter.sv */
// ----------------------------------------------------------------------------
// si_prefix_value_formatter: value to display characters with SI prefix
// Flow: the front end converts the magnitude to BCD at 2 bits per cycle, takes
// 0 to 6 rounding steps and queues the record; the back end pops it, sets up and
// then sends the characters one per cycle, 1 to 8 of them.
// The front end takes no new item until the last one's record is in the queue.
// Reset: control state cleared, prefix registers load their defaults.
// ----------------------------------------------------------------------------
module si_prefix_value_formatter #(
   parameter int MAX_DIGITS = sipf_pkg::MAX_DIGITS_DEF,
   parameter int QDEPTH     = sipf_pkg::QDEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [sipf_pkg::VAL_W-1:0]          req_value,
   input  logic signed [sipf_pkg::EXP_W-1:0]   req_exponent,
   input  logic [sipf_pkg::CHR_W-1:0]          req_unit,
   output logic                                rsp_valid,
   output logic [sipf_pkg::CHR_W-1:0]          rsp_char_out,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [sipf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sipf_pkg::CHR_W-1:0]          csr_wdata
);
   import sipf_pkg::*;

   prefix_tab_type prefix_ff;
   rec_type        push_data;
   rec_type        pop_data;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   // indexes past the prefix table are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PREFIX_RESET;
      end else if (csr_we && (csr_index < CSR_IDX_W'(NUM_PREFIX))) begin
         prefix_ff[csr_index] <= csr_wdata;
      end
   end

   sipf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_exponent (req_exponent),
      .req_unit     (req_unit),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (push_data)
   );

   sipf_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (push_data),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (pop_data),
      .empty    (q_empty)
   );

   sipf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (pop_data),
      .q_pop        (q_pop),
      .prefix_tab   (prefix_ff),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

/* rtl/core/sipf_checker.sv */
// ----------------------------------------------------------------------------
// sipf_checker: port level checks for the formatter
// Watches the command and result ports; attached by bind.
// ----------------------------------------------------------------------------
module sipf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [sipf_pkg::CHR_W-1:0]          rsp_char_out,
   input logic                                rsp_last
);

   // an accepted item keeps the front end busy through conversion
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy ##1 busy)
      else $error("busy dropped right after an accepted item");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !rsp_last)
      else $error("result strobe right after reset");

   a_last_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last flag without a result");

   // every character sent is a real code: zero prefix or unit is skipped
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out != '0))
      else $error("zero character sent");

endmodule

bind si_prefix_value_formatter sipf_checker u_sipf_checker (.*);

/* tb/si_prefix_value_formatter_tb.sv */
// ----------------------------------------------------------------------------
// si_prefix_value_formatter_tb: self-checking bench for the SI prefix formatter
// Drives values through the start/busy port and rebuilds each display string
// in a scoreboard: sign, rounding to four digits, decimal point, prefix and
// unit. Every character and its last flag are checked in order. The prefix
// table is reloaded between phases (all zero, all ones, random, defaults).
// ----------------------------------------------------------------------------
module si_prefix_value_formatter_tb;
   import sipf_pkg::*;

   localparam int          MAX_DIGITS   = MAX_DIGITS_DEF;
   localparam longint      DIGIT_LIMIT  = 64'd10 ** MAX_DIGITS;
   localparam int          LIMIT_CYCLES = 200000;
   localparam int          DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [CHR_W-1:0] ch;
      logic             last;
   } disp_char_type;

   typedef enum {TAB_ZERO, TAB_FULL, TAB_RANDOM, TAB_DEFAULT} table_fill_type;

   // scoreboard: holds the prefix table copy and the expected character stream
   class char_scoreboard;
      logic [CHR_W-1:0] prefix_tab [NUM_PREFIX];
      disp_char_type    expected_chars [$];
      int               errors;

      function new();
         int i;
         for (i = 0; i < NUM_PREFIX; i++)
            prefix_tab[i] = PREFIX_RESET[i];
         errors = 0;
      endfunction

      function void set_prefix(int idx, logic [CHR_W-1:0] ch);
         prefix_tab[idx] = ch;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // build the display string for one accepted item
      function void note_value(logic sgn, logic [VAL_W-1:0] raw,
                               logic signed [EXP_W-1:0] exponent,
                               logic [CHR_W-1:0] unit);
         logic [63:0]      mag;
         logic [63:0]      t;
         int               expo, e, idx, offset, len, pos, i;
         logic [CHR_W-1:0] prefix;
         logic [3:0]       digs [24];
         logic [CHR_W-1:0] text [$];
         disp_char_type    dc;

         expo   = exponent;
         offset = 0;
         prefix = '0;
         mag    = {32'd0, raw};
         if (sgn && raw[VAL_W-1]) begin
            text.push_back(CHAR_MINUS);
            mag = {32'd0, ~raw + 32'd1};
            if (mag == 0)
               mag = 64'h8000_0000;
         end

         // round half up one digit at a time; 64 bits so the add never wraps
         while (mag >= DIGIT_LIMIT) begin
            mag = (mag + 64'd5) / 64'd10;
            expo++;
         end

         if (expo >= EXPO_PICO) begin
            e      = expo - EXPO_PICO;
            idx    = e / 3;
            offset = e % 3;
            if (offset > 0) begin
               idx++;
               offset = 3 - offset;
            end
            if (idx >= 0 && idx < NUM_PREFIX)
               prefix = prefix_tab[idx];
         end

         len = 0;
         t   = mag;
         do begin
            digs[len] = 4'(t % 64'd10);
            t = t / 64'd10;
            len++;
         end while (t != 0 && len < 24);

         pos = len - offset;
         if (pos <= 0) begin
            text.push_back(CHAR_ZERO);
            text.push_back(CHAR_DOT);
            if (pos < 0)
               text.push_back(CHAR_ZERO);
         end
         if (offset == 0)
            pos = -1;
         pos--;

         for (i = 0; i < len; i++) begin
            text.push_back(CHAR_ZERO + 8'(digs[len-1-i]));
            if (i == pos)
               text.push_back(CHAR_DOT);
         end

         if (prefix != 0)
            text.push_back(prefix);
         if (unit != 0)
            text.push_back(unit);

         for (i = 0; i < text.size(); i++) begin
            dc.ch   = text[i];
            dc.last = (i == text.size() - 1);
            expected_chars.push_back(dc);
         end
      endfunction

      function void check_char(logic [CHR_W-1:0] ch, logic last);
         disp_char_type dc;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected char %0d last %0d", $time, ch, last);
            errors++;
            return;
         end
         dc = expected_chars.pop_front();
         if (ch !== dc.ch) begin
            $display("%0t: char mismatch, expected %0d actual %0d", $time, dc.ch, ch);
            errors++;
         end
         if (last !== dc.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d",
                     $time, dc.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      start        = 1'b0;
   logic                      busy;
   logic                      req_func     = 1'b0;
   logic [VAL_W-1:0]          req_value    = '0;
   logic signed [EXP_W-1:0]   req_exponent = '0;
   logic [CHR_W-1:0]          req_unit     = '0;
   logic                      rsp_valid;
   logic [CHR_W-1:0]          rsp_char_out;
   logic                      rsp_last;
   logic                      csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index    = '0;
   logic [CHR_W-1:0]          csr_wdata    = '0;

   char_scoreboard sb;
   int             cycles = 0;

   si_prefix_value_formatter u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_exponent (req_exponent),
      .req_unit     (req_unit),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_value(req_func, req_value, req_exponent, req_unit);
      if (!reset && rsp_valid)
         sb.check_char(rsp_char_out, rsp_last);
   end

   task automatic send_value(input logic f, input logic [VAL_W-1:0] v,
                             input int x, input logic [CHR_W-1:0] u);
      @(negedge clock);
      req_func     = f;
      req_value    = v;
      req_exponent = x[EXP_W-1:0];
      req_unit     = u;
      start        = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_input(input int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_idle(input bit gaps);
      if (gaps && $urandom_range(0, 2) == 0)
         idle_input($urandom_range(1, 9));
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   task automatic load_prefixes(input table_fill_type fill);
      int               i;
      logic [CHR_W-1:0] ch;
      for (i = 0; i < NUM_PREFIX; i++) begin
         case (fill)
            TAB_ZERO:    ch = '0;
            TAB_FULL:    ch = '1;
            TAB_RANDOM:  ch = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            default:     ch = PREFIX_RESET[i];
         endcase
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = CSR_IDX_W'(i);
         csr_wdata = ch;
         sb.set_prefix(i, ch);
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      longint p;
      longint step;
      int     k;
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 99);
         2: return $urandom_range(0, 200000);
         3: begin
            // at or just under a power of ten, where rounding may carry
            k = $urandom_range(MAX_DIGITS, 9);
            p = 64'd10 ** k;
            step = (p >= 20000) ? p / 20000 : 1;
            return VAL_W'(p - $urandom_range(0, 8) * step);
         end
         default: return VAL_W'(-$urandom_range(0, 100000));
      endcase
   endfunction

   function automatic int pick_exponent();
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 63) - 32;
      return $urandom_range(0, 26) - 16;
   endfunction

   task automatic run_random(input int count, input bit gaps);
      int               n;
      logic [CHR_W-1:0] u;
      for (n = 0; n < count; n++) begin
         maybe_idle(gaps);
         u = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom());
         send_value($urandom_range(0, 1), pick_value(), pick_exponent(), u);
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed items at the default prefix table
      send_value(0, 32'd0,         0,   "V");
      maybe_idle(1);
      send_value(0, 32'hFFFF_FFFF, 0,   8'd0);
      send_value(1, 32'hFFFF_FFFF, 0,   "A");
      maybe_idle(1);
      send_value(1, 32'h8000_0000, 0,   "V");   // most negative signed value
      send_value(1, 32'h7FFF_FFFF, -3,  "V");
      send_value(0, 32'd1,         -32, "F");   // far below pico
      maybe_idle(1);
      send_value(0, 32'd1234,      -12, "F");
      send_value(0, 32'd1234,      -13, "F");   // just below pico, no prefix
      send_value(0, 32'd99995,     -15, "s");   // rounding carry
      send_value(0, 32'd99995,     0,   "s");
      maybe_idle(1);
      send_value(0, 32'd5,         -1,  "s");   // leading 0.
      send_value(0, 32'd5,         -2,  "s");   // leading 0.0
      send_value(0, 32'd42,        -2,  8'd0);
      send_value(0, 32'd1,         31,  8'hFF); // far above mega
      maybe_idle(1);
      send_value(0, 32'd123,       7,   "W");   // just above mega
      send_value(0, 32'd123,       6,   "W");
      send_value(0, 32'd9999,      -4,  "H");
      send_value(1, 32'd12345678,  -6,  "A");
      send_value(0, 32'd10000,     0,   "m");
      send_value(1, 32'h8000_0001, 30,  8'd0);
      send_value(0, 32'd0,         -32, 8'd0);
      drain();

      load_prefixes(TAB_ZERO);
      run_random(25, 1);
      drain();
      load_prefixes(TAB_FULL);
      run_random(25, 1);
      drain();
      load_prefixes(TAB_RANDOM);
      run_random(20, 1);
      drain();
      load_prefixes(TAB_RANDOM);
      run_random(20, 1);
      drain();
      load_prefixes(TAB_DEFAULT);
      run_random(40, 0);   // back-to-back to the end
      drain();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
